// File: src/assert_macros.svh
// shared assertion macros for the keyer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/ipk_pkg.sv
package ipk_pkg;

  // input ops
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PADDLE = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  // keyer modes
  localparam logic [1:0] KM_STRAIGHT = 2'd0;
  localparam logic [1:0] KM_IAMBIC_A = 2'd1;
  localparam logic [1:0] KM_IAMBIC_B = 2'd2;

  // keyer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_KEYER_MODE  = 3'd0;
  localparam logic [2:0] REG_SWAP        = 3'd1;
  localparam logic [2:0] REG_DOT_UNIT    = 3'd2;
  localparam logic [2:0] REG_MARK_WEIGHT = 3'd3;
  localparam logic [2:0] REG_STUCK_LIMIT = 3'd4;

  // reset values of the configuration
  localparam logic [11:0] DOT_UNIT_RST    = 12'd60;
  localparam logic [6:0]  WEIGHT_NOMINAL  = 7'd50;
  localparam logic [15:0] STUCK_LIMIT_RST = 16'd15000;

  // counter limits
  localparam logic [14:0] ELAPSED_MAX = 15'h7fff;
  localparam logic [15:0] SINCE_MAX   = 16'hffff;

  // unit ticks times weight, mark length in fiftieths of a tick
  localparam int BASE_W = 19;
  localparam int LEN_W  = 21;
  localparam int THR_W  = 22;

  typedef struct packed {
    logic [1:0]        keyer_mode;
    logic              swap_paddles;
    logic [11:0]       dot_unit_ticks;
    logic [15:0]       stuck_limit_ticks;
    logic [BASE_W-1:0] mark_base;
  } cfg_t;

  typedef struct packed {
    logic       paddle_pressed;
    logic       paddle_sel;
    logic [1:0] op;
  } item_t;

  typedef struct packed {
    logic       stuck_released;
    logic [1:0] keyer_phase;
    logic       element_kind;
    logic       mark_started;
    logic       key_on;
  } result_t;

  // weight 0 stands for nominal
  function automatic logic [6:0] eff_weight(input logic [6:0] w);
    eff_weight = (w == 7'd0) ? WEIGHT_NOMINAL : w;
  endfunction

endpackage

// File: src/iambic_paddle_keyer.sv
// Iambic paddle keyer, Curtis mode A and B plus straight key. Each input beat
// is a tick, a paddle press/release or a keyer reset, and each gives exactly one
// output beat with the key level and keyer phase after it. The block takes one
// beat per clock cycle while the output is not stalled; an input register and
// an output register sit around a single pass of keyer logic. Mark length is
// unit ticks times weight over 50, compared against 50 times the elapsed count,
// so no divider is used; the unit times weight product is refreshed by the
// configuration writes themselves. Configuration is to be written by the user
// only while no beat is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module iambic_paddle_keyer import ipk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // op[1:0], paddle_sel[2], paddle_pressed[3], zero
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key_on[0], mark_started[1], element_kind[2],
                                 // keyer_phase[4:3], stuck_released[5], zero
  // configuration writes
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  cfg_t        cfg;
  logic [11:0] unit_wr;
  logic [6:0]  weight, weight_wr;
  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  result_t     core_res;
  logic        load_ok, fire;

  // configuration registers, product kept in step with unit and weight
  always_comb begin
    unit_wr   = wr_data[11:0];
    weight_wr = wr_data[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keyer_mode        <= KM_IAMBIC_A;
      cfg.swap_paddles      <= 1'b0;
      cfg.dot_unit_ticks    <= DOT_UNIT_RST;
      cfg.stuck_limit_ticks <= STUCK_LIMIT_RST;
      cfg.mark_base         <= BASE_W'(DOT_UNIT_RST * WEIGHT_NOMINAL);
      weight                <= WEIGHT_NOMINAL;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEYER_MODE:  cfg.keyer_mode <= wr_data[1:0];
        REG_SWAP:        cfg.swap_paddles <= wr_data[0];
        REG_DOT_UNIT: begin
          cfg.dot_unit_ticks <= unit_wr;
          cfg.mark_base      <= BASE_W'(unit_wr) * BASE_W'(eff_weight(weight));
        end
        REG_MARK_WEIGHT: begin
          weight        <= weight_wr;
          cfg.mark_base <= BASE_W'(cfg.dot_unit_ticks) * BASE_W'(eff_weight(weight_wr));
        end
        REG_STUCK_LIMIT: cfg.stuck_limit_ticks <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // input register takes a beat whenever the keyer stage can move on
  assign load_ok  = !out_valid || m_tready;
  assign fire     = in_valid && load_ok;
  assign s_tready = !in_valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) in_item <= item_t'(s_tdata[3:0]);
  end

  ipk_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_res <= core_res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  `ASSERT_CLK(a_start_keys, (m_tvalid && out_res.mark_started) |-> (out_res.key_on && out_res.keyer_phase == PH_MARK), "mark start without key down")
  `ASSERT_CLK(a_no_drop, (out_valid && !m_tready) |-> !fire, "result overwritten while stalled")

endmodule

// File: src/ipk_core.sv
`include "assert_macros.svh"

module ipk_core import ipk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic        dot_contact, dash_contact;
  logic [1:0]  phase;
  logic        element;
  logic        dit_memory, dah_memory;
  logic [14:0] elapsed_ticks;
  logic [15:0] since_change_ticks;
  logic        key_level;

  logic        dot_contact_next, dash_contact_next;
  logic [1:0]  phase_next;
  logic        element_next;
  logic        dit_memory_next, dah_memory_next;
  logic [14:0] elapsed_ticks_next;
  logic [15:0] since_change_ticks_next;
  logic        key_level_next;
  logic        started, stuck;

  // next state of the keyer for one item
  always_comb begin
    logic              ld, lh;
    logic              mem, held, same;
    logic              have_next, next_el;
    logic [15:0]       cnt1;
    logic [THR_W-1:0]  thresh;
    logic [LEN_W-1:0]  base_ext, mark_len;
    logic [11:0]       space_len;

    dot_contact_next        = dot_contact;
    dash_contact_next       = dash_contact;
    phase_next              = phase;
    element_next            = element;
    dit_memory_next         = dit_memory;
    dah_memory_next         = dah_memory;
    elapsed_ticks_next      = elapsed_ticks;
    since_change_ticks_next = since_change_ticks;
    key_level_next          = key_level;
    started                 = 1'b0;
    stuck                   = 1'b0;
    ld        = 1'b0;
    lh        = 1'b0;
    mem       = 1'b0;
    held      = 1'b0;
    same      = 1'b0;
    have_next = 1'b0;
    next_el   = 1'b0;
    cnt1      = '0;
    thresh    = '0;
    base_ext  = LEN_W'(cfg.mark_base);
    mark_len  = '0;
    space_len = (cfg.dot_unit_ticks == 12'd0) ? 12'd1 : cfg.dot_unit_ticks;

    case (item.op)
      OP_TICK: begin
        if (since_change_ticks != SINCE_MAX) begin
          since_change_ticks_next = since_change_ticks + 16'd1;
        end
        if (cfg.keyer_mode == KM_STRAIGHT) begin
          // straight key drops any element in flight
          if (phase != PH_IDLE) begin
            if (phase == PH_MARK) key_level_next = 1'b0;
            phase_next   = PH_IDLE;
            element_next = 1'b0;
          end
        end else begin
          // stuck paddle guard
          if ((dot_contact || dash_contact) &&
              (since_change_ticks_next > cfg.stuck_limit_ticks)) begin
            dot_contact_next  = 1'b0;
            dash_contact_next = 1'b0;
            stuck             = 1'b1;
          end
          ld = cfg.swap_paddles ? dash_contact_next : dot_contact_next;
          lh = cfg.swap_paddles ? dot_contact_next : dash_contact_next;
          if (phase == PH_IDLE) begin
            // dot wins a squeeze from idle
            if (ld || lh) begin
              have_next = 1'b1;
              next_el   = !ld;
            end
          end else begin
            // latch the opposite paddle
            if (element) begin
              if (ld) dit_memory_next = 1'b1;
            end else if (lh) begin
              dah_memory_next = 1'b1;
            end
            if (elapsed_ticks != ELAPSED_MAX) begin
              elapsed_ticks_next = elapsed_ticks + 15'd1;
            end
            if (phase == PH_MARK) begin
              // mark ends once 50 * (elapsed + 1) exceeds unit * weight * len
              cnt1     = {1'b0, elapsed_ticks_next} + 16'd1;
              thresh   = {1'b0, cnt1, 5'b0} + {2'b0, cnt1, 4'b0} + {5'b0, cnt1, 1'b0};
              mark_len = element ? ((base_ext << 1) + base_ext) : base_ext;
              if (thresh > THR_W'(mark_len)) begin
                key_level_next     = 1'b0;
                elapsed_ticks_next = '0;
                phase_next         = PH_SPACE;
              end
            end else if (elapsed_ticks_next >= 15'(space_len)) begin
              // pick the next element
              mem  = element ? dit_memory_next : dah_memory_next;
              held = element ? ld : lh;
              same = element ? lh : ld;
              if (mem && ((cfg.keyer_mode == KM_IAMBIC_B) || held)) begin
                have_next = 1'b1;
                next_el   = !element;
              end else if (same) begin
                have_next = 1'b1;
                next_el   = element;
              end else if (ld) begin
                have_next = 1'b1;
                next_el   = 1'b0;
              end else if (lh) begin
                have_next = 1'b1;
                next_el   = 1'b1;
              end
              dit_memory_next = 1'b0;
              dah_memory_next = 1'b0;
              if (!have_next) begin
                phase_next         = PH_IDLE;
                element_next       = 1'b0;
                elapsed_ticks_next = '0;
              end
            end
          end
          // start a new mark
          if (have_next) begin
            element_next       = next_el;
            elapsed_ticks_next = '0;
            phase_next         = PH_MARK;
            key_level_next     = 1'b1;
            dit_memory_next    = next_el && ld;
            dah_memory_next    = !next_el && lh;
            started            = 1'b1;
          end
        end
      end
      OP_PADDLE: begin
        if (item.paddle_sel) dash_contact_next = item.paddle_pressed;
        else                 dot_contact_next  = item.paddle_pressed;
        since_change_ticks_next = '0;
        ld = cfg.swap_paddles ? dash_contact_next : dot_contact_next;
        lh = cfg.swap_paddles ? dot_contact_next : dash_contact_next;
        if (cfg.keyer_mode == KM_STRAIGHT) begin
          if (item.paddle_sel == cfg.swap_paddles) key_level_next = item.paddle_pressed;
        end else if (item.paddle_pressed && (phase != PH_IDLE)) begin
          if (element) begin
            if (ld) dit_memory_next = 1'b1;
          end else if (lh) begin
            dah_memory_next = 1'b1;
          end
        end
      end
      OP_RESET: begin
        dot_contact_next   = 1'b0;
        dash_contact_next  = 1'b0;
        dit_memory_next    = 1'b0;
        dah_memory_next    = 1'b0;
        phase_next         = PH_IDLE;
        element_next       = 1'b0;
        elapsed_ticks_next = '0;
        key_level_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result fields after this item
  always_comb begin
    res.key_on         = key_level_next;
    res.mark_started   = started;
    res.element_kind   = element_next;
    res.keyer_phase    = phase_next;
    res.stuck_released = stuck;
  end

  // keyer state
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_contact        <= 1'b0;
      dash_contact       <= 1'b0;
      phase              <= PH_IDLE;
      element            <= 1'b0;
      dit_memory         <= 1'b0;
      dah_memory         <= 1'b0;
      elapsed_ticks      <= '0;
      since_change_ticks <= '0;
      key_level          <= 1'b0;
    end else if (fire) begin
      dot_contact        <= dot_contact_next;
      dash_contact       <= dash_contact_next;
      phase              <= phase_next;
      element            <= element_next;
      dit_memory         <= dit_memory_next;
      dah_memory         <= dah_memory_next;
      elapsed_ticks      <= elapsed_ticks_next;
      since_change_ticks <= since_change_ticks_next;
      key_level          <= key_level_next;
    end
  end

  `ASSERT_CLK(a_one_memory, !(dit_memory && dah_memory), "both paddle memories set")
  `ASSERT_CLK(a_stuck_clears, (fire && stuck) |=> (!dot_contact && !dash_contact), "stuck release left a contact held")
  `ASSERT_CLK(a_stuck_on_tick, stuck |-> (item.op == OP_TICK && cfg.keyer_mode != KM_STRAIGHT), "stuck release outside an iambic tick")

endmodule
